>>> src/mkc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and profile coefficients for the musical key classifier.
// No dependencies; used by every module of the block.
package mkc_pkg;

    localparam int NUM_BINS   = 12;
    localparam int WEIGHT_W   = 16;
    // profile coefficient pre-multiplied by the Q16 reciprocal norm
    localparam int COEF_BITS  = 22;
    // headroom for summing twelve coefficients (sum of each table < 2^25)
    localparam int SCORE_EXTRA = 25;

    localparam int RECIP_MAJOR = 5107;
    localparam int RECIP_MINOR = 4870;

    localparam logic OP_NOTE     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef struct packed {
        logic        op;
        logic [6:0]  pitch;
        logic [15:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [3:0] key_root;
        logic       is_minor;
    } t_out_item;

    // candidate key carried alongside the MAC pipeline
    typedef struct packed {
        logic [3:0] root;
        logic       minor;
        logic       final_cand;
    } t_cand;

    typedef struct packed {
        logic  valid;
        logic  first;
        logic  last;
        t_cand cand;
    } t_mac_ctl;

    typedef struct packed {
        logic  valid;
        t_cand cand;
    } t_mac_res;

    // pitch mod 12 via reciprocal multiply: floor(p*43/512) == floor(p/12) for p < 128
    function automatic logic [3:0] pitch_class(input logic [6:0] p);
        logic [12:0] prod;
        logic [3:0]  q;
        logic [6:0]  q12;
        logic [6:0]  rem;
        prod = 13'(p) * 13'd43;
        q    = prod[12:9];
        q12  = 7'(q) * 7'd12;
        rem  = p - q12;
        return rem[3:0];
    endfunction

    function automatic logic [COEF_BITS-1:0] coef(input logic minor, input logic [3:0] j);
        logic [COEF_BITS-1:0] c;
        c = '0;
        if (!minor) begin
            case (j)
                4'd0:  c = COEF_BITS'(635 * RECIP_MAJOR);
                4'd1:  c = COEF_BITS'(223 * RECIP_MAJOR);
                4'd2:  c = COEF_BITS'(348 * RECIP_MAJOR);
                4'd3:  c = COEF_BITS'(233 * RECIP_MAJOR);
                4'd4:  c = COEF_BITS'(438 * RECIP_MAJOR);
                4'd5:  c = COEF_BITS'(409 * RECIP_MAJOR);
                4'd6:  c = COEF_BITS'(252 * RECIP_MAJOR);
                4'd7:  c = COEF_BITS'(519 * RECIP_MAJOR);
                4'd8:  c = COEF_BITS'(239 * RECIP_MAJOR);
                4'd9:  c = COEF_BITS'(366 * RECIP_MAJOR);
                4'd10: c = COEF_BITS'(229 * RECIP_MAJOR);
                4'd11: c = COEF_BITS'(288 * RECIP_MAJOR);
                default: c = '0;
            endcase
        end else begin
            case (j)
                4'd0:  c = COEF_BITS'(633 * RECIP_MINOR);
                4'd1:  c = COEF_BITS'(268 * RECIP_MINOR);
                4'd2:  c = COEF_BITS'(352 * RECIP_MINOR);
                4'd3:  c = COEF_BITS'(538 * RECIP_MINOR);
                4'd4:  c = COEF_BITS'(260 * RECIP_MINOR);
                4'd5:  c = COEF_BITS'(353 * RECIP_MINOR);
                4'd6:  c = COEF_BITS'(254 * RECIP_MINOR);
                4'd7:  c = COEF_BITS'(475 * RECIP_MINOR);
                4'd8:  c = COEF_BITS'(398 * RECIP_MINOR);
                4'd9:  c = COEF_BITS'(269 * RECIP_MINOR);
                4'd10: c = COEF_BITS'(334 * RECIP_MINOR);
                4'd11: c = COEF_BITS'(317 * RECIP_MINOR);
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

>>> src/mkc_hist.sv
`timescale 1ns / 1ps
// Twelve-bin pitch-class histogram with saturating add, bulk clear and one read port.
// Depends on mkc_pkg.
module mkc_hist #(
    parameter int HIST_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_add,
    input  logic [3:0]                    i_bin,
    input  logic [mkc_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic                          i_clear,
    input  logic [3:0]                    i_rd_idx,
    output logic [HIST_BITS-1:0]          o_rd_data
);

    logic [HIST_BITS-1:0] r_hist [mkc_pkg::NUM_BINS];
    logic [HIST_BITS:0]   w_sum;

    assign w_sum = {1'b0, r_hist[i_bin]}
                 + {{(HIST_BITS + 1 - mkc_pkg::WEIGHT_W){1'b0}}, i_weight};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int k = 0; k < mkc_pkg::NUM_BINS; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_add) begin
            // carry out means the bin saturates
            r_hist[i_bin] <= w_sum[HIST_BITS] ? {HIST_BITS{1'b1}} : w_sum[HIST_BITS-1:0];
        end
    end

    assign o_rd_data = r_hist[i_rd_idx];

endmodule

>>> src/mkc_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one bin times one scaled coefficient per cycle,
// twelve products summed into one candidate score. Depends on mkc_pkg.
module mkc_mac #(
    parameter int HIST_BITS = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  mkc_pkg::t_mac_ctl                          i_ctl,
    input  logic [HIST_BITS-1:0]                       i_hist,
    input  logic [mkc_pkg::COEF_BITS-1:0]              i_coef,
    output mkc_pkg::t_mac_res                          o_res,
    output logic [HIST_BITS+mkc_pkg::SCORE_EXTRA-1:0]  o_score
);

    localparam int PROD_W = HIST_BITS + mkc_pkg::COEF_BITS;
    localparam int ACC_W  = HIST_BITS + mkc_pkg::SCORE_EXTRA;

    mkc_pkg::t_mac_ctl   r_ctl;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    mkc_pkg::t_mac_res   r_res;
    logic [ACC_W-1:0]    r_score;

    assign n_acc = (r_ctl.first ? '0 : r_acc) + {{(ACC_W - PROD_W){1'b0}}, r_prod};

    // only the valid bits are reset; the datapath fields follow them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
            r_res.valid <= r_ctl.valid && r_ctl.last;
        end
        r_ctl.first <= i_ctl.first;
        r_ctl.last  <= i_ctl.last;
        r_ctl.cand  <= i_ctl.cand;
        r_prod      <= PROD_W'(i_hist) * PROD_W'(i_coef);
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
        if (r_ctl.valid && r_ctl.last) begin
            r_score    <= n_acc;
            r_res.cand <= r_ctl.cand;
        end
    end

    assign o_res   = r_res;
    assign o_score = r_score;

endmodule

>>> src/musical_key_classifier_unit.sv
`timescale 1ns / 1ps
// Krumhansl-Schmuckler key finder. Note transactions: one per cycle while busy is low, no result.
// Classify transaction: 24 keys x 12 bins = 288 MACs through one shared multiplier,
// result strobe after the last minor-key score is compared; busy drops in the strobe cycle.
// The receiver cannot stall: o_valid lasts exactly one cycle.
// Synchronous active-low reset clears the histogram and the sequencer.
module musical_key_classifier_unit #(
    parameter int WEIGHT_BITS = 16,
    parameter int HIST_BITS   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mkc_pkg::t_in_item     i_in,
    output logic                  o_valid,
    output mkc_pkg::t_out_item    o_out
);

    localparam int SCORE_W = HIST_BITS + mkc_pkg::SCORE_EXTRA;
    localparam int WB_EFF  = (WEIGHT_BITS < mkc_pkg::WEIGHT_W) ? WEIGHT_BITS
                                                                : mkc_pkg::WEIGHT_W;
    localparam logic [mkc_pkg::WEIGHT_W-1:0] W_MASK =
        mkc_pkg::WEIGHT_W'((33'd1 << WB_EFF) - 33'd1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [3:0]            r_j, n_j;
    logic [3:0]            r_root, n_root;
    logic                  r_minor, n_minor;
    logic                  r_out_valid;
    mkc_pkg::t_out_item    r_out;

    logic [SCORE_W-1:0]    r_best_score;
    logic [3:0]            r_best_root;
    logic                  r_best_minor;

    logic                  w_accept;
    logic                  w_note;
    logic                  w_classify;
    logic                  w_done;
    logic                  w_gt;
    logic [4:0]            w_idx_sum;
    logic [3:0]            w_rd_idx;
    logic [HIST_BITS-1:0]  w_hist;
    mkc_pkg::t_mac_ctl     w_ctl;
    mkc_pkg::t_mac_res     w_res;
    logic [SCORE_W-1:0]    w_score;
    logic [3:0]            w_win_root;
    logic                  w_win_minor;

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_note     = w_accept && (i_in.op == mkc_pkg::OP_NOTE);
    assign w_classify = w_accept && (i_in.op == mkc_pkg::OP_CLASSIFY);
    assign w_done     = w_res.valid && w_res.cand.final_cand;

    // bin read for the rotated profile: (j + root) mod 12
    assign w_idx_sum = {1'b0, r_j} + {1'b0, r_root};
    assign w_rd_idx  = (w_idx_sum >= 5'd12) ? 4'(w_idx_sum - 5'd12) : w_idx_sum[3:0];

    assign w_ctl.valid           = (r_state == S_ISSUE);
    assign w_ctl.first           = (r_j == 4'd0);
    assign w_ctl.last            = (r_j == 4'd11);
    assign w_ctl.cand.root       = r_root;
    assign w_ctl.cand.minor      = r_minor;
    assign w_ctl.cand.final_cand = r_minor && (r_root == 4'd11);

    mkc_hist #(
        .HIST_BITS (HIST_BITS)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_add     (w_note),
        .i_bin     (mkc_pkg::pitch_class(i_in.pitch)),
        .i_weight  (i_in.weight & W_MASK),
        .i_clear   (w_done),
        .i_rd_idx  (w_rd_idx),
        .o_rd_data (w_hist)
    );

    mkc_mac #(
        .HIST_BITS (HIST_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_hist  (w_hist),
        .i_coef  (mkc_pkg::coef(r_minor, r_j)),
        .o_res   (w_res),
        .o_score (w_score)
    );

    // sequencer: j innermost, then root, major pass before minor pass
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_root  = r_root;
        n_minor = r_minor;
        unique case (r_state)
            S_IDLE: begin
                if (w_classify) begin
                    n_state = S_ISSUE;
                    n_j     = 4'd0;
                    n_root  = 4'd0;
                    n_minor = 1'b0;
                end
            end
            S_ISSUE: begin
                if (r_j == 4'd11) begin
                    n_j = 4'd0;
                    if (r_root == 4'd11) begin
                        n_root = 4'd0;
                        if (r_minor) begin
                            n_state = S_DRAIN;
                        end else begin
                            n_minor = 1'b1;
                        end
                    end else begin
                        n_root = r_root + 4'd1;
                    end
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_DRAIN: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // strict greater-than keeps the earliest best key
    assign w_gt        = w_score > r_best_score;
    assign w_win_root  = w_gt ? w_res.cand.root  : r_best_root;
    assign w_win_minor = w_gt ? w_res.cand.minor : r_best_minor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_j         <= 4'd0;
            r_root      <= 4'd0;
            r_minor     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_root      <= n_root;
            r_minor     <= n_minor;
            r_out_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_classify) begin
            // empty histogram leaves C major
            r_best_score <= '0;
            r_best_root  <= 4'd0;
            r_best_minor <= 1'b0;
        end else if (w_res.valid) begin
            if (w_gt) begin
                r_best_score <= w_score;
            end
            r_best_root  <= w_win_root;
            r_best_minor <= w_win_minor;
        end
        if (w_done) begin
            r_out.key_root <= w_win_root;
            r_out.is_minor <= w_win_minor;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_DRAIN)
        else $error("result strobe without a finished classify pass");

    a_idle_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy still high in the result cycle");

    a_classify_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.op == mkc_pkg::OP_CLASSIFY) |=> busy)
        else $error("classify transaction did not start the sequencer");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.key_root <= 4'd11)
        else $error("key root out of range");

endmodule
